### src/srd_pkg.sv
// Shared types and constants for the SDNV record deserializer.
// Used by srd_front, srd_queue, srd_back and sdnv_record_deserializer.
package srd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEFT_W     = 21;
    localparam int NODE_W     = 64;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 16;
    localparam int RECLEN_W   = 17;
    localparam int CNT_W      = 4;

    // Largest number of bytes an SDNV node number may span.
    localparam logic [CNT_W-1:0] MAX_SDNV_BYTES = 4'd10;
    // Bytes of fixed fields that follow the SDNV: two times and the length.
    localparam logic [LEFT_W-1:0] FIXED_TAIL_BYTES = 21'd10;
    localparam logic [CNT_W-1:0] TIME_BYTES = 4'd4;
    localparam logic [CNT_W-1:0] LEN_BYTES  = 4'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_TOO_SHORT = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef enum logic [2:0] {
        PH_SDNV,
        PH_EFF,
        PH_ASSERT,
        PH_LEN,
        PH_DATA
    } t_phase;

    // What one input byte asked the back end to deliver.
    typedef enum logic [2:0] {
        OP_HEADER,
        OP_HEADER_END,
        OP_DATA,
        OP_DATA_END,
        OP_ERROR
    } t_op_code;

    typedef struct packed {
        t_op_code              op;
        logic [NODE_W-1:0]     node_number;
        logic [TIME_W-1:0]     effective_time;
        logic [TIME_W-1:0]     assertion_time;
        logic [LEN_W-1:0]      data_length;
        logic [BYTE_W-1:0]     payload_byte;
        logic [RECLEN_W-1:0]   record_length;
        logic [1:0]            error_code;
    } t_op;

    // Read request from the back end to the queue.
    typedef struct packed {
        logic pop;
    } t_qread;

endpackage

### src/srd_front.sv
// Front end: field parser that turns each accepted byte into at most one queue entry.
// Depends on srd_pkg.
module srd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [srd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic [srd_pkg::LEFT_W-1:0]   i_bytes_left,
    input  logic                         i_cfg_write,
    input  logic [srd_pkg::LEN_W-1:0]    i_cfg_data,
    output logic                         o_push,
    output srd_pkg::t_op                 o_entry
);
    import srd_pkg::*;

    logic [LEN_W-1:0]    r_max_len;
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [TIME_W-1:0]   r_eff, n_eff;
    logic [TIME_W-1:0]   r_asr, n_asr;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [RECLEN_W-1:0] r_consumed, n_consumed;

    logic [CNT_W-1:0]    cnt_inc;
    logic [RECLEN_W-1:0] consumed_inc;
    logic [NODE_W-1:0]   node_sh;
    logic [LEN_W-1:0]    len_sh;
    logic [LEN_W-1:0]    rem_dec;
    logic [LEFT_W-1:0]   len_plus_one;
    logic                clear;

    assign cnt_inc      = r_cnt + 1'b1;
    assign consumed_inc = r_consumed + 1'b1;
    assign node_sh      = {r_node[NODE_W-8:0], i_in_byte[6:0]};
    assign len_sh       = {r_len[LEN_W-BYTE_W-1:0], i_in_byte};
    assign rem_dec      = r_rem - 1'b1;
    assign len_plus_one = {{(LEFT_W-LEN_W){1'b0}}, len_sh} + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = cnt_inc;
        n_node     = r_node;
        n_eff      = r_eff;
        n_asr      = r_asr;
        n_len      = r_len;
        n_rem      = r_rem;
        n_consumed = consumed_inc;
        clear      = 1'b0;
        o_push     = 1'b0;
        o_entry    = '0;
        o_entry.op = OP_ERROR;

        unique case (r_phase)
            PH_EFF: begin
                n_eff = {r_eff[TIME_W-BYTE_W-1:0], i_in_byte};
                if (cnt_inc >= TIME_BYTES) begin
                    n_phase = PH_ASSERT;
                    n_cnt   = '0;
                end
            end
            PH_ASSERT: begin
                n_asr = {r_asr[TIME_W-BYTE_W-1:0], i_in_byte};
                if (cnt_inc >= TIME_BYTES) begin
                    n_phase = PH_LEN;
                    n_cnt   = '0;
                end
            end
            PH_LEN: begin
                n_len = len_sh;
                if (cnt_inc >= LEN_BYTES) begin
                    if (len_sh > r_max_len) begin
                        o_push             = 1'b1;
                        o_entry.error_code = ERR_TOO_LONG;
                        clear              = 1'b1;
                    end else if (i_bytes_left < len_plus_one) begin
                        o_push             = 1'b1;
                        o_entry.error_code = ERR_TRUNCATED;
                        clear              = 1'b1;
                    end else begin
                        o_push                 = 1'b1;
                        o_entry.node_number    = r_node;
                        o_entry.effective_time = r_eff;
                        o_entry.assertion_time = r_asr;
                        o_entry.data_length    = len_sh;
                        if (len_sh == '0) begin
                            // Empty record: the header and the end share this byte.
                            o_entry.op            = OP_HEADER_END;
                            o_entry.record_length = consumed_inc;
                            clear                 = 1'b1;
                        end else begin
                            o_entry.op = OP_HEADER;
                            n_phase    = PH_DATA;
                            n_cnt      = '0;
                            n_rem      = len_sh;
                        end
                    end
                end
            end
            PH_DATA: begin
                n_rem                = rem_dec;
                o_push               = 1'b1;
                o_entry.payload_byte = i_in_byte;
                if (rem_dec == '0) begin
                    o_entry.op            = OP_DATA_END;
                    o_entry.record_length = consumed_inc;
                    clear                 = 1'b1;
                end else begin
                    o_entry.op = OP_DATA;
                end
            end
            default: begin
                // SDNV phase; unused phase codes fall here as well.
                n_phase = PH_SDNV;
                n_node  = node_sh;
                if (i_in_byte[7]) begin
                    if (i_bytes_left <= 21'd1 || cnt_inc >= MAX_SDNV_BYTES) begin
                        o_push             = 1'b1;
                        o_entry.error_code = ERR_TOO_SHORT;
                        clear              = 1'b1;
                    end
                end else if (i_bytes_left <= FIXED_TAIL_BYTES) begin
                    o_push             = 1'b1;
                    o_entry.error_code = ERR_TOO_SHORT;
                    clear              = 1'b1;
                end else begin
                    n_phase = PH_EFF;
                    n_cnt   = '0;
                end
            end
        endcase

        if (clear) begin
            n_phase    = PH_SDNV;
            n_cnt      = '0;
            n_node     = '0;
            n_eff      = '0;
            n_asr      = '0;
            n_len      = '0;
            n_rem      = '0;
            n_consumed = '0;
        end

        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= '1;
            r_phase    <= PH_SDNV;
            r_cnt      <= '0;
            r_node     <= '0;
            r_eff      <= '0;
            r_asr      <= '0;
            r_len      <= '0;
            r_rem      <= '0;
            r_consumed <= '0;
        end else begin
            if (i_cfg_write) begin
                r_max_len <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_node     <= n_node;
                r_eff      <= n_eff;
                r_asr      <= n_asr;
                r_len      <= n_len;
                r_rem      <= n_rem;
                r_consumed <= n_consumed;
            end
        end
    end

endmodule

### src/srd_queue.sv
// Short queue of parsed entries between the front end and the back end.
// Depends on srd_pkg.
module srd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srd_pkg::t_op  i_entry,
    output logic          o_full,
    input  srd_pkg::t_qread i_rd,
    output logic          o_empty,
    output srd_pkg::t_op  o_head
);
    import srd_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_rd.pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/srd_back.sv
// Back end: expands each queue entry into one or two result beats.
// Depends on srd_pkg.
module srd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srd_pkg::t_op                  i_head,
    input  logic                          i_q_empty,
    output srd_pkg::t_qread               o_rd,
    input  logic                          pop,
    output logic                          empty,
    output logic [1:0]                    o_kind,
    output logic [srd_pkg::NODE_W-1:0]    o_node_number,
    output logic [srd_pkg::TIME_W-1:0]    o_effective_time,
    output logic [srd_pkg::TIME_W-1:0]    o_assertion_time,
    output logic [srd_pkg::LEN_W-1:0]     o_data_length,
    output logic [srd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [srd_pkg::RECLEN_W-1:0]  o_record_length,
    output logic [1:0]                    o_error_code,
    output logic                          o_last_of_run
);
    import srd_pkg::*;

    logic r_second;
    logic has_end;
    logic take;

    assign has_end = (i_head.op == OP_HEADER_END) || (i_head.op == OP_DATA_END);
    assign empty   = i_q_empty;
    assign take    = pop && !i_q_empty;

    assign o_rd.pop   = take && !(has_end && !r_second);

    always_comb begin
        o_kind           = KIND_ERROR;
        o_node_number    = '0;
        o_effective_time = '0;
        o_assertion_time = '0;
        o_data_length    = '0;
        o_payload_byte   = '0;
        o_record_length  = '0;
        o_error_code     = '0;
        o_last_of_run    = !(has_end && !r_second);
        if (r_second) begin
            o_kind          = KIND_END;
            o_record_length = i_head.record_length;
        end else begin
            unique case (i_head.op)
                OP_HEADER, OP_HEADER_END: begin
                    o_kind           = KIND_HEADER;
                    o_node_number    = i_head.node_number;
                    o_effective_time = i_head.effective_time;
                    o_assertion_time = i_head.assertion_time;
                    o_data_length    = i_head.data_length;
                end
                OP_DATA, OP_DATA_END: begin
                    o_kind         = KIND_DATA;
                    o_payload_byte = i_head.payload_byte;
                end
                default: begin
                    o_kind       = KIND_ERROR;
                    o_error_code = i_head.error_code;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= has_end && !r_second;
        end
    end

endmodule

### src/sdnv_record_deserializer.sv
// Top level of the SDNV length-prefixed record deserializer.
// Depends on srd_pkg, srd_front, srd_queue and srd_back.
//
// The block parses a record buffer one byte per beat: an SDNV node number of at most
// ten bytes, a big-endian 32-bit effective time, a 32-bit assertion time, a 16-bit data
// length and the data bytes. Each input beat carries the byte and the number of buffer
// bytes remaining from it onward. Results come out of a queue-style port: a header beat,
// one beat per data byte, an end beat that carries the consumed record length, or an
// error beat (too short, data too long, data truncated); last_of_run marks the final
// result that one input byte caused. The front parser takes one byte every clock cycle
// as long as its four-entry result queue has room, so full depends only on how fast the
// consumer pops. The back end delivers one result per cycle on pop; the byte ending an
// empty record or the last data byte yields two results and so holds its queue entry for
// two pops. The data-length limit register may be written at any time through the cfg
// channel, which is always ready, but is meant to change only while the block is idle.
// After an end or an error the parser waits for the first SDNV byte of the next record.
module sdnv_record_deserializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [srd_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic [srd_pkg::LEFT_W-1:0]    i_bytes_left,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srd_pkg::LEN_W-1:0]     i_cfg_max_data_length,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_kind,
    output logic [srd_pkg::NODE_W-1:0]    o_node_number,
    output logic [srd_pkg::TIME_W-1:0]    o_effective_time,
    output logic [srd_pkg::TIME_W-1:0]    o_assertion_time,
    output logic [srd_pkg::LEN_W-1:0]     o_data_length,
    output logic [srd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [srd_pkg::RECLEN_W-1:0]  o_record_length,
    output logic [1:0]                    o_error_code,
    output logic                          o_last_of_run
);
    import srd_pkg::*;

    // An input beat is taken only while the queue is not full, even if it yields nothing.
    logic   accept;
    logic   q_push;
    logic   q_empty;
    t_op    q_entry;
    t_op    q_head;
    t_qread q_rd;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    srd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_bytes_left (i_bytes_left),
        .i_cfg_write  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_max_data_length),
        .o_push       (q_push),
        .o_entry      (q_entry)
    );

    // The queue decouples the parser from a stalled consumer.
    srd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    srd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .i_q_empty        (q_empty),
        .o_rd             (q_rd),
        .pop              (pop),
        .empty            (empty),
        .o_kind           (o_kind),
        .o_node_number    (o_node_number),
        .o_effective_time (o_effective_time),
        .o_assertion_time (o_assertion_time),
        .o_data_length    (o_data_length),
        .o_payload_byte   (o_payload_byte),
        .o_record_length  (o_record_length),
        .o_error_code     (o_error_code),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

### tb/sv/tb_sdnv_record_deserializer.sv
// Self-checking testbench for sdnv_record_deserializer: it drives record bytes and
// predicts header, data, end and error beats against its own parser model.
// Depends on srd_pkg and the sdnv_record_deserializer RTL only.
module tb_sdnv_record_deserializer;
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 16;    // covers front, queue and back end with margin
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat moving on any channel
    localparam int HALF_BEATS   = 188;   // six halves of random traffic, about 1150 in all

    // One input beat: the raw byte and the buffer bytes left from it onward.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [LEFT_W-1:0] remaining;
    } t_stream_beat;

    // One result beat as it should appear on the output ports.
    typedef struct packed {
        logic [1:0]          kind;
        logic [NODE_W-1:0]   node_number;
        logic [TIME_W-1:0]   effective_time;
        logic [TIME_W-1:0]   assertion_time;
        logic [LEN_W-1:0]    data_length;
        logic [BYTE_W-1:0]   payload_byte;
        logic [RECLEN_W-1:0] record_length;
        logic [1:0]          error_code;
        logic                last_of_run;
    } t_parse_result;

    // Shapes of generated records: well formed, or broken at one chosen byte.
    typedef enum int {
        REC_GOOD,
        REC_SDNV_CUT,       // buffer ends inside the node number
        REC_SDNV_OVERLONG,  // node number still continuing at its tenth byte
        REC_SHORT_TAIL,     // fewer than ten bytes left after the node number
        REC_TOO_LONG,       // data length above the configured maximum
        REC_TRUNCATED       // buffer ends before the data does
    } t_rec_flaw;

    logic                i_clk                 = 1'b0;
    logic                i_rst_n               = 1'b0;
    logic                push                  = 1'b0;
    logic                full;
    logic [BYTE_W-1:0]   i_in_byte             = '0;
    logic [LEFT_W-1:0]   i_bytes_left          = 21'd1;
    logic                i_cfg_valid           = 1'b0;
    logic                o_cfg_ready;
    logic [LEN_W-1:0]    i_cfg_max_data_length = '1;
    logic                empty;
    logic                pop                   = 1'b0;
    logic [1:0]          o_kind;
    logic [NODE_W-1:0]   o_node_number;
    logic [TIME_W-1:0]   o_effective_time;
    logic [TIME_W-1:0]   o_assertion_time;
    logic [LEN_W-1:0]    o_data_length;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic [RECLEN_W-1:0] o_record_length;
    logic [1:0]          o_error_code;
    logic                o_last_of_run;

    sdnv_record_deserializer i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_in_byte             (i_in_byte),
        .i_bytes_left          (i_bytes_left),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_max_data_length (i_cfg_max_data_length),
        .empty                 (empty),
        .pop                   (pop),
        .o_kind                (o_kind),
        .o_node_number         (o_node_number),
        .o_effective_time      (o_effective_time),
        .o_assertion_time      (o_assertion_time),
        .o_data_length         (o_data_length),
        .o_payload_byte        (o_payload_byte),
        .o_record_length       (o_record_length),
        .o_error_code          (o_error_code),
        .o_last_of_run         (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Beats waiting to be sent, and result beats predicted but not yet seen.
    t_stream_beat  pending_beats[$];
    t_parse_result expected_results[$];

    // Idle rates in percent for the sending and the receiving side.
    int unsigned sender_idle_pct = 26;
    int unsigned recv_idle_pct   = 87;

    int beats_queued   = 0;
    int beats_accepted = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int kind_seen[4]   = '{default: 0};
    int error_seen[4]  = '{default: 0};

    // Parser model state. The data-length limit mirrors the register and changes only
    // when a configuration beat has gone through, which happens only while idle.
    t_phase              prs_phase;
    logic [CNT_W-1:0]    prs_count;
    logic [NODE_W-1:0]   prs_node;
    logic [TIME_W-1:0]   prs_eff;
    logic [TIME_W-1:0]   prs_asr;
    logic [LEN_W-1:0]    prs_len;
    logic [LEN_W-1:0]    prs_remaining;
    logic [RECLEN_W-1:0] prs_consumed;
    logic [LEN_W-1:0]    max_len_setting = '1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    function automatic t_parse_result blank_result(input logic [1:0] kind);
        t_parse_result r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    task automatic clear_record();
        prs_phase     = PH_SDNV;
        prs_count     = '0;
        prs_node      = '0;
        prs_eff       = '0;
        prs_asr       = '0;
        prs_len       = '0;
        prs_remaining = '0;
        prs_consumed  = '0;
    endtask

    // Any error ends the record; the byte that caused it counts as consumed.
    task automatic post_error(input logic [1:0] code);
        t_parse_result r;
        r = blank_result(KIND_ERROR);
        r.error_code  = code;
        r.last_of_run = 1'b1;
        expected_results.push_back(r);
        clear_record();
    endtask

    task automatic post_end();
        t_parse_result r;
        r = blank_result(KIND_END);
        r.record_length = prs_consumed;
        r.last_of_run   = 1'b1;
        expected_results.push_back(r);
        clear_record();
    endtask

    // Advances the parser model by one accepted byte and queues what it yields.
    // The tag is looked at only on node number bytes and on the last length byte.
    task automatic parse_beat(input logic [BYTE_W-1:0] b, input logic [LEFT_W-1:0] tag);
        t_parse_result r;
        prs_consumed = prs_consumed + 1'b1;
        case (prs_phase)
            PH_EFF: begin
                prs_eff   = {prs_eff[TIME_W-9:0], b};
                prs_count = prs_count + 1'b1;
                if (prs_count >= TIME_BYTES) begin
                    prs_phase = PH_ASSERT;
                    prs_count = '0;
                end
            end
            PH_ASSERT: begin
                prs_asr   = {prs_asr[TIME_W-9:0], b};
                prs_count = prs_count + 1'b1;
                if (prs_count >= TIME_BYTES) begin
                    prs_phase = PH_LEN;
                    prs_count = '0;
                end
            end
            PH_LEN: begin
                prs_len   = {prs_len[7:0], b};
                prs_count = prs_count + 1'b1;
                if (prs_count >= LEN_BYTES) begin
                    // The limit is checked before the buffer size.
                    if (prs_len > max_len_setting) begin
                        post_error(ERR_TOO_LONG);
                    end else if (32'(tag) < 32'(prs_len) + 32'd1) begin
                        post_error(ERR_TRUNCATED);
                    end else begin
                        r = blank_result(KIND_HEADER);
                        r.node_number    = prs_node;
                        r.effective_time = prs_eff;
                        r.assertion_time = prs_asr;
                        r.data_length    = prs_len;
                        r.last_of_run    = (prs_len != '0);
                        expected_results.push_back(r);
                        // An empty record ends on the same byte as its header.
                        if (prs_len == '0) begin
                            post_end();
                        end else begin
                            prs_phase     = PH_DATA;
                            prs_count     = '0;
                            prs_remaining = prs_len;
                        end
                    end
                end
            end
            PH_DATA: begin
                r = blank_result(KIND_DATA);
                r.payload_byte = b;
                prs_remaining  = prs_remaining - 1'b1;
                r.last_of_run  = (prs_remaining != '0);
                expected_results.push_back(r);
                if (prs_remaining == '0)
                    post_end();
            end
            default: begin
                // Node number: seven bits per byte, wrapping past 64 bits.
                prs_node  = {prs_node[NODE_W-8:0], b[6:0]};
                prs_count = prs_count + 1'b1;
                if (b[7]) begin
                    if (tag <= 1 || prs_count >= MAX_SDNV_BYTES)
                        post_error(ERR_TOO_SHORT);
                end else if (tag < FIXED_TAIL_BYTES + 1) begin
                    post_error(ERR_TOO_SHORT);
                end else begin
                    prs_phase = PH_EFF;
                    prs_count = '0;
                end
            end
        endcase
    endtask

    task automatic queue_beat(input logic [BYTE_W-1:0] value, input logic [LEFT_W-1:0] tag);
        pending_beats.push_back('{value: value, remaining: tag});
        beats_queued++;
    endtask

    // Builds one record with random content. Broken records stop at the byte that
    // breaks them; the tag there is chosen to trigger exactly that error.
    task automatic queue_record(input t_rec_flaw flaw_in);
        t_rec_flaw         flaw;
        logic [BYTE_W-1:0] rec[$];
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0]  len;
        logic [LEFT_W-1:0] tag;
        int                sdnv_n;
        int                check_idx;
        int                len_idx;
        int                n;
        int                slack;
        int                hi;
        int unsigned       pick;
        flaw = flaw_in;
        if (flaw == REC_TOO_LONG && max_len_setting == '1)
            flaw = REC_TRUNCATED;
        if (flaw == REC_TRUNCATED && max_len_setting == '0)
            flaw = REC_GOOD;

        // Mostly short node numbers, now and then the full ten bytes (these wrap).
        sdnv_n = ($urandom_range(0, 7) == 0) ? int'(MAX_SDNV_BYTES)
                                             : int'($urandom_range(1, 3));
        if (flaw == REC_SDNV_OVERLONG)
            sdnv_n = int'(MAX_SDNV_BYTES);
        if (flaw == REC_SDNV_CUT && sdnv_n == 1)
            sdnv_n = 2;
        for (int i = 0; i < sdnv_n; i++) begin
            b    = 8'($urandom_range(0, 255));
            b[7] = (i < sdnv_n - 1) || (flaw == REC_SDNV_OVERLONG);
            rec.push_back(b);
        end

        check_idx = -1;
        case (flaw)
            REC_SDNV_CUT:                      check_idx = int'($urandom_range(0, sdnv_n - 2));
            REC_SDNV_OVERLONG, REC_SHORT_TAIL: check_idx = sdnv_n - 1;
            default: ;
        endcase

        repeat (2 * TIME_BYTES) rec.push_back(8'($urandom_range(0, 255)));

        case (flaw)
            REC_TOO_LONG: begin
                if ($urandom_range(0, 1))
                    len = max_len_setting + 1'b1;
                else
                    len = 16'($urandom_range(int'(max_len_setting) + 1, 65535));
            end
            REC_TRUNCATED: begin
                hi  = ($urandom_range(0, 1) && max_len_setting > 20) ? 20
                                                                     : int'(max_len_setting);
                len = 16'($urandom_range(1, hi));
            end
            default: begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    len = 16'($urandom_range(0, 3));
                else if (pick < 90)
                    len = 16'($urandom_range(4, 12));
                else
                    len = 16'($urandom_range(13, 60));
                if (len > max_len_setting)
                    len = max_len_setting;
            end
        endcase
        len_idx = rec.size() + 1;
        rec.push_back(len[15:8]);
        rec.push_back(len[7:0]);
        if (flaw == REC_TOO_LONG || flaw == REC_TRUNCATED)
            check_idx = len_idx;
        if (flaw == REC_GOOD)
            repeat (len) rec.push_back(8'($urandom_range(0, 255)));
        n = (check_idx >= 0) ? check_idx + 1 : rec.size();

        // The buffer usually ends with the record, sometimes well past it.
        pick = $urandom_range(0, 9);
        if (pick < 6)
            slack = 0;
        else if (pick < 9)
            slack = int'($urandom_range(1, 40));
        else
            slack = int'($urandom_range(0, (1 << 20) - n));

        for (int i = 0; i < n; i++) begin
            tag = 21'(n - i + slack);
            if (i == check_idx) begin
                case (flaw)
                    REC_SDNV_CUT:   tag = 21'd1;
                    REC_SHORT_TAIL: tag = 21'($urandom_range(1, FIXED_TAIL_BYTES));
                    REC_TRUNCATED:  tag = 21'($urandom_range(1, len));
                    default: ;
                endcase
            end else if (i >= sdnv_n && i != len_idx && $urandom_range(0, 7) == 0) begin
                // The parser ignores tags on these bytes, so garbage is fair.
                tag = 21'($urandom_range(1, 1 << 20));
            end
            queue_beat(rec[i], tag);
        end
    endtask

    task automatic run_traffic(input int beats);
        int          stop_at;
        int unsigned pick;
        stop_at = beats_queued + beats;
        while (beats_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_record(REC_GOOD);
            else if (pick < 92)
                queue_record(t_rec_flaw'($urandom_range(1, 5)));
            else
                repeat ($urandom_range(1, 4))
                    queue_beat(8'($urandom_range(0, 255)),
                               $urandom_range(0, 1) ? 21'($urandom_range(1, FIXED_TAIL_BYTES))
                                                    : 21'($urandom_range(1, 1 << 20)));
        end
    endtask

    // Holds the sender back until every beat is sent and every result has arrived,
    // then lets the pipeline settle in case the last bytes produced nothing.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || push || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] limit);
        @(posedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_max_data_length <= limit;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        max_len_setting  = limit;
    endtask

    // Sender. A beat that is offered while full stays on the ports unchanged; otherwise
    // the next beat goes out unless this cycle is picked to idle. Each accepted beat
    // feeds the parser model at the edge where it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_beat(i_in_byte, i_bytes_left);
                pending_beats.delete(0);
                beats_accepted++;
            end
            if (!(push && full)) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    push         <= 1'b1;
                    i_in_byte    <= pending_beats[0].value;
                    i_bytes_left <= pending_beats[0].remaining;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every popped beat is checked field by field against the oldest
    // prediction; pop is raised at random per cycle.
    always @(posedge i_clk) begin : result_monitor
        t_parse_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result of kind %0d with none expected", o_kind));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(o_kind), 64'(want.kind));
                    check_field("node_number", o_node_number, want.node_number);
                    check_field("effective_time", 64'(o_effective_time),
                                64'(want.effective_time));
                    check_field("assertion_time", 64'(o_assertion_time),
                                64'(want.assertion_time));
                    check_field("data_length", 64'(o_data_length), 64'(want.data_length));
                    check_field("payload_byte", 64'(o_payload_byte), 64'(want.payload_byte));
                    check_field("record_length", 64'(o_record_length),
                                64'(want.record_length));
                    check_field("error_code", 64'(o_error_code), 64'(want.error_code));
                    check_field("last_of_run", 64'(o_last_of_run), 64'(want.last_of_run));
                    kind_seen[want.kind]++;
                    if (want.kind == KIND_ERROR)
                        error_seen[want.error_code]++;
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] one_byte_rec [13];
        logic [LEN_W-1:0]  limits [6];
        // Two-byte node number 0x3F80, fixed times, one data byte of all ones.
        one_byte_rec = '{8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
                         8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'h00, 8'h01,
                         8'hFF};
        clear_record();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the limit at its reset value.
        // A continuing node number byte on the very last buffer byte.
        queue_beat(8'h80, 21'd1);
        // A complete node number with only nine bytes after it.
        queue_beat(8'h05, 21'd10);
        // Empty record with exactly the bytes it needs: header and end from one byte.
        // The time bytes carry extreme tags, which must be ignored.
        queue_beat(8'h7F, 21'd11);
        repeat (4) queue_beat(8'hFF, 21'd1);
        repeat (4) queue_beat(8'h00, 21'd1048576);
        queue_beat(8'h00, 21'd2);
        queue_beat(8'h00, 21'd1);
        // One data byte: data beat and end beat from the last byte, tags exact.
        for (int i = 0; i < 13; i++)
            queue_beat(one_byte_rec[i], 21'(13 - i));
        wait_drained();

        // Random traffic in six halves, each with its own limit, both extremes among
        // them. The drain between halves is also the sender's long pause.
        limits = '{16'hFFFF, 16'h0000, 16'($urandom_range(4, 40)),
                   16'($urandom_range(0, 65535)), 16'h0001, 16'hFFFF};
        for (int h = 0; h < 6; h++) begin
            if (h == 2) begin
                sender_idle_pct = 87;
                recv_idle_pct   = 26;
            end else if (h == 4) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            write_max_len(limits[h]);
            run_traffic(HALF_BEATS);
            wait_drained();
        end

        $display("covered %0d input beats: %0d headers, %0d data beats, %0d record ends",
                 beats_accepted, kind_seen[KIND_HEADER], kind_seen[KIND_DATA],
                 kind_seen[KIND_END]);
        $display("errors seen: %0d too short, %0d data too long, %0d truncated",
                 error_seen[ERR_TOO_SHORT], error_seen[ERR_TOO_LONG],
                 error_seen[ERR_TRUNCATED]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
